// ----- hdl/ccc_pkg.sv -----
// Shared types, codes and helpers for the correction confusion counter.
// No dependencies; RTL uses scoped names into it, the bench imports it.
package ccc_pkg;

  localparam int MIS_W       = 11;
  localparam int CNT_OUT_W   = 48;
  localparam int OUT_DEPTH   = 3;

  typedef enum logic [1:0] {
    ACT_COMPARE   = 2'd0,
    ACT_READ_CAT  = 2'd1,
    ACT_READ_HIST = 2'd2,
    ACT_NONE      = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    CAT_TP = 2'd0,
    CAT_FP = 2'd1,
    CAT_FN = 2'd2,
    CAT_TN = 2'd3
  } cat_t;

  typedef struct packed {
    cat_t             category;
    logic [MIS_W-1:0] read_mismatches;
  } cls_t;

  typedef struct packed {
    cat_t                 category;
    logic [MIS_W-1:0]     read_mismatches;
    logic [CNT_OUT_W-1:0] tp_total;
    logic [CNT_OUT_W-1:0] fp_total;
    logic [CNT_OUT_W-1:0] fn_total;
    logic [CNT_OUT_W-1:0] tn_total;
    logic [CNT_OUT_W-1:0] hist_count;
  } rsp_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (b >= 8'h61 && b <= 8'h7a) begin
      v = b - 8'h20;
    end
    return v;
  endfunction

endpackage

// ----- hdl/ccc_ifs.sv -----
// Request and result channel interfaces, valid/ready handshake.
// Depends on ccc_pkg for the action code type.
interface ccc_in_if;
  logic           valid;
  logic           ready;
  ccc_pkg::act_t  action;
  logic [7:0]     original_base;
  logic [7:0]     true_base;
  logic [7:0]     corrected_base;
  logic [5:0]     quality_bin;
  logic           end_of_read;
  logic [5:0]     hist_index;

  modport source(output valid, action, original_base, true_base, corrected_base,
                 quality_bin, end_of_read, hist_index, input ready);
  modport sink(input valid, action, original_base, true_base, corrected_base,
               quality_bin, end_of_read, hist_index, output ready);
endinterface

interface ccc_out_if;
  logic         valid;
  logic         ready;
  logic [1:0]   category;
  logic [10:0]  read_mismatches;
  logic [47:0]  tp_total;
  logic [47:0]  fp_total;
  logic [47:0]  fn_total;
  logic [47:0]  tn_total;
  logic [47:0]  hist_count;

  modport source(output valid, category, read_mismatches, tp_total, fp_total,
                 fn_total, tn_total, hist_count, input ready);
  modport sink(input valid, category, read_mismatches, tp_total, fp_total,
               fn_total, tn_total, hist_count, output ready);
endinterface

// ----- hdl/correction_confusion_counter.sv -----
// Top level of the correction confusion counter: classify, counter RMW, result buffer.
// Depends on ccc_pkg, ccc_ifs, ccc_ram, ccc_classify and ccc_out_fifo.
//
//   channel    dir   payload
//   in_chan    in    action, original/true/corrected base, quality_bin, end_of_read,
//                    hist_index
//   out_chan   out   category, read_mismatches, tp/fp/fn/tn totals, hist_count
//
// One request per cycle while ready is high; each result is registered in the update
// stage and then in the result buffer. Counters live in two RAMs with registered read;
// the update stage writes back in the cycle after the read and forwards its write to
// the request right behind it. After reset a clear sweep zeroes both counter RAMs with
// ready low. A three-entry result buffer holds results while out_chan stalls; ready
// drops once the buffer plus the update stage hold three results.
module correction_confusion_counter #(
  parameter int QUAL_BINS    = 64,
  parameter int HIST_BINS    = 64,
  parameter int MAX_READ_LEN = 1024,
  parameter int COUNT_BITS   = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  ccc_in_if.sink    in_chan,
  ccc_out_if.source out_chan
);

  localparam int CAW    = (QUAL_BINS > 1) ? $clog2(QUAL_BINS) : 1;
  localparam int HBW    = $clog2(HIST_BINS);
  localparam int HDEPTH = QUAL_BINS * HIST_BINS;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int CB     = COUNT_BITS;
  localparam int ROW_W  = 4 * COUNT_BITS;

  // clear sweep
  logic           clearing_r, clearing_nxt;
  logic [HAW-1:0] clr_idx_r, clr_idx_nxt;

  // request side
  logic           accept;
  logic [1:0]     fifo_count;
  ccc_pkg::cls_t  cls;
  logic [HBW-1:0] run_bin;
  logic [CAW-1:0] q_sel;
  logic [HBW-1:0] bin_sel;
  logic           idx_hit;
  logic [HAW-1:0] haddr;

  // update stage
  logic           s1_valid_r;
  ccc_pkg::act_t  s1_action_r;
  ccc_pkg::cat_t  s1_cat_r;
  logic [CAW-1:0] s1_caddr_r;
  logic [HAW-1:0] s1_haddr_r;
  logic           s1_hit_r;
  logic           s1_eor_r;
  logic [ccc_pkg::MIS_W-1:0] s1_rmis_r;

  // RAM ports and forwarding
  logic [ROW_W-1:0] cat_rdata, cat_row, cat_new, cat_wdata;
  logic [CB-1:0]    hist_rdata, hist_val, hist_new, hist_wdata;
  logic [CB-1:0]    lane [4];
  logic             cat_upd, hist_upd, cat_we, hist_we;
  logic [CAW-1:0]   cat_waddr;
  logic [HAW-1:0]   hist_waddr;
  logic             cfw_valid_r, hfw_valid_r;
  logic [CAW-1:0]   cfw_addr_r;
  logic [HAW-1:0]   hfw_addr_r;
  logic [ROW_W-1:0] cfw_data_r;
  logic [CB-1:0]    hfw_data_r;
  ccc_pkg::rsp_t    rsp;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !clearing_r && ((3'(fifo_count) + 3'(s1_valid_r)) < 3'(ccc_pkg::OUT_DEPTH));

  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + HAW'(1);
      if (clr_idx_r == HAW'(HDEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  ccc_classify #(
    .HIST_BINS    (HIST_BINS),
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_classify (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .action         (in_chan.action),
    .original_base  (in_chan.original_base),
    .true_base      (in_chan.true_base),
    .corrected_base (in_chan.corrected_base),
    .end_of_read    (in_chan.end_of_read),
    .cls            (cls),
    .hist_bin       (run_bin)
  );

  always_comb begin
    q_sel   = (32'(in_chan.quality_bin) >= QUAL_BINS) ? CAW'(QUAL_BINS - 1)
                                                      : CAW'(in_chan.quality_bin);
    idx_hit = 32'(in_chan.hist_index) < HIST_BINS;
    bin_sel = (in_chan.action == ccc_pkg::ACT_COMPARE) ? run_bin
                                                       : HBW'(32'(in_chan.hist_index));
    haddr   = HAW'(q_sel) * HAW'(HIST_BINS) + HAW'(bin_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_chan.action;
      s1_cat_r    <= cls.category;
      s1_caddr_r  <= q_sel;
      s1_haddr_r  <= haddr;
      s1_hit_r    <= idx_hit;
      s1_eor_r    <= in_chan.end_of_read;
      s1_rmis_r   <= cls.read_mismatches;
    end
  end

  ccc_ram #(.WIDTH(ROW_W), .DEPTH(QUAL_BINS)) u_cat_ram (
    .clk   (clk),
    .we    (cat_we),
    .waddr (cat_waddr),
    .wdata (cat_wdata),
    .raddr (q_sel),
    .rdata (cat_rdata)
  );

  ccc_ram #(.WIDTH(CB), .DEPTH(HDEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (haddr),
    .rdata (hist_rdata)
  );

  always_comb begin
    cat_row  = (cfw_valid_r && cfw_addr_r == s1_caddr_r) ? cfw_data_r : cat_rdata;
    hist_val = (hfw_valid_r && hfw_addr_r == s1_haddr_r) ? hfw_data_r : hist_rdata;
    cat_upd  = s1_valid_r && s1_action_r == ccc_pkg::ACT_COMPARE;
    hist_upd = cat_upd && s1_eor_r;
    cat_new  = cat_row;
    for (int k = 0; k < 4; k++) begin
      lane[k] = cat_row[k*CB +: CB];
      if (2'(k) == s1_cat_r) begin
        cat_new[k*CB +: CB] = (lane[k] == '1) ? lane[k] : lane[k] + CB'(1);
      end
    end
    hist_new = (hist_val == '1) ? hist_val : hist_val + CB'(1);
  end

  always_comb begin
    if (clearing_r) begin
      cat_we     = 32'(clr_idx_r) < QUAL_BINS;
      cat_waddr  = clr_idx_r[CAW-1:0];
      cat_wdata  = '0;
      hist_we    = 1'b1;
      hist_waddr = clr_idx_r;
      hist_wdata = '0;
    end else begin
      cat_we     = cat_upd;
      cat_waddr  = s1_caddr_r;
      cat_wdata  = cat_new;
      hist_we    = hist_upd;
      hist_waddr = s1_haddr_r;
      hist_wdata = hist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfw_valid_r <= 1'b0;
      hfw_valid_r <= 1'b0;
    end else begin
      cfw_valid_r <= cat_upd;
      hfw_valid_r <= hist_upd;
    end
  end

  always_ff @(posedge clk) begin
    cfw_addr_r <= s1_caddr_r;
    cfw_data_r <= cat_new;
    hfw_addr_r <= s1_haddr_r;
    hfw_data_r <= hist_new;
  end

  always_comb begin
    rsp                 = '0;
    rsp.read_mismatches = s1_rmis_r;
    case (s1_action_r)
      ccc_pkg::ACT_COMPARE: begin
        rsp.category = s1_cat_r;
      end
      ccc_pkg::ACT_READ_CAT: begin
        rsp.tp_total = ccc_pkg::CNT_OUT_W'(lane[ccc_pkg::CAT_TP]);
        rsp.fp_total = ccc_pkg::CNT_OUT_W'(lane[ccc_pkg::CAT_FP]);
        rsp.fn_total = ccc_pkg::CNT_OUT_W'(lane[ccc_pkg::CAT_FN]);
        rsp.tn_total = ccc_pkg::CNT_OUT_W'(lane[ccc_pkg::CAT_TN]);
      end
      ccc_pkg::ACT_READ_HIST: begin
        rsp.hist_count = s1_hit_r ? ccc_pkg::CNT_OUT_W'(hist_val) : '0;
      end
      default: begin
        rsp.category = ccc_pkg::CAT_TP;
      end
    endcase
  end

  ccc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (rsp),
    .count     (fifo_count),
    .out_chan  (out_chan)
  );

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_chan.ready)
    else $error("request taken during clear sweep");

  a_sweep_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> $past(clr_idx_r) == HAW'(HDEPTH - 1))
    else $error("clear sweep ended early");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_chan.valid)
    else $error("update stage result lost");

  a_hist_only_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (!clearing_r && hist_we) |-> (cat_we && s1_eor_r))
    else $error("histogram written outside end of read");

endmodule

// ----- hdl/ccc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
module ccc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ccc_classify.sv -----
// Base classifier and per-read mismatch run register.
// Depends on ccc_pkg for codes, the case fold and the classifier result struct.
module ccc_classify #(
  parameter int HIST_BINS    = 64,
  parameter int MAX_READ_LEN = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  ccc_pkg::act_t                action,
  input  logic [7:0]                   original_base,
  input  logic [7:0]                   true_base,
  input  logic [7:0]                   corrected_base,
  input  logic                         end_of_read,
  output ccc_pkg::cls_t                cls,
  output logic [$clog2(HIST_BINS)-1:0] hist_bin
);

  localparam int RW  = $clog2(MAX_READ_LEN + 1);
  localparam int HBW = $clog2(HIST_BINS);

  logic [RW-1:0] run_r, run_nxt, run_inc;
  logic [7:0]    r_up, p_up, c_up;
  ccc_pkg::cat_t cat;
  logic          mis;

  always_comb begin
    r_up = ccc_pkg::fold_upper(original_base);
    p_up = ccc_pkg::fold_upper(true_base);
    c_up = ccc_pkg::fold_upper(corrected_base);
    if (r_up != p_up) begin
      cat = (c_up == p_up) ? ccc_pkg::CAT_TP : ccc_pkg::CAT_FN;
    end else begin
      cat = (c_up == p_up) ? ccc_pkg::CAT_TN : ccc_pkg::CAT_FP;
    end
    mis = (cat == ccc_pkg::CAT_FP) || (cat == ccc_pkg::CAT_FN);
    run_inc = (mis && (32'(run_r) < MAX_READ_LEN)) ? run_r + RW'(1) : run_r;
  end

  always_comb begin
    cls.category        = cat;
    cls.read_mismatches = (action == ccc_pkg::ACT_COMPARE) ? ccc_pkg::MIS_W'(run_inc)
                                                           : ccc_pkg::MIS_W'(run_r);
    hist_bin = (32'(run_inc) >= HIST_BINS - 1) ? HBW'(HIST_BINS - 1) : HBW'(run_inc);
  end

  always_comb begin
    run_nxt = run_r;
    if (accept && action == ccc_pkg::ACT_COMPARE) begin
      run_nxt = end_of_read ? '0 : run_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && action == ccc_pkg::ACT_COMPARE && end_of_read |=> run_r == '0)
    else $error("mismatch run not cleared at end of read");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(run_r) <= MAX_READ_LEN)
    else $error("mismatch run beyond read length limit");

endmodule

// ----- hdl/ccc_out_fifo.sv -----
// Three-entry result buffer that drives the result channel.
// Depends on ccc_pkg (result struct) and ccc_ifs (result interface).
module ccc_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ccc_pkg::rsp_t push_data,
  output logic [1:0]    count,
  ccc_out_if.source     out_chan
);

  localparam int FD = ccc_pkg::OUT_DEPTH;

  ccc_pkg::rsp_t buf_r [FD];
  logic [1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          pop;
  ccc_pkg::rsp_t head;

  assign pop  = out_chan.valid && out_chan.ready;
  assign head = buf_r[rd_ptr_r];

  always_comb begin
    out_chan.valid           = (count_r != 2'd0);
    out_chan.category        = head.category;
    out_chan.read_mismatches = head.read_mismatches;
    out_chan.tp_total        = head.tp_total;
    out_chan.fp_total        = head.fp_total;
    out_chan.fn_total        = head.fn_total;
    out_chan.tn_total        = head.tn_total;
    out_chan.hist_count      = head.hist_count;
    count                    = count_r;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == 2'(FD - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == 2'(FD - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && count_r == 2'(FD)))
    else $error("result buffer overflow");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty buffer with pointers apart");

endmodule

// ----- tb/correction_confusion_counter_tb.sv -----
// Self-checking bench for correction_confusion_counter: directed table, then random reads.
// Results are scored against an in-bench model of the per-quality tallies and histogram,
// or against the pinned table row. Depends on ccc_pkg, ccc_ifs and the RTL under hdl.
module correction_confusion_counter_tb;
  import ccc_pkg::*;

  localparam int QUAL_BINS    = 64;
  localparam int HIST_BINS    = 64;
  localparam int MAX_READ_LEN = 1024;
  localparam int ITEMS        = 1850;
  localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    act_t       action;
    logic [7:0] orig_b;
    logic [7:0] true_b;
    logic [7:0] corr_b;
    logic [5:0] qual;
    logic       eor;
    logic [5:0] hidx;
  } base_req_t;

  typedef struct packed {
    logic             pinned;
    base_req_t        rq;
    cat_t             cat;
    logic [MIS_W-1:0] mis;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b1, '{ACT_READ_CAT,  8'h00, 8'h00, 8'h00, 6'd0,  1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b1, '{ACT_READ_HIST, 8'h00, 8'h00, 8'h00, 6'd63, 1'b0, 6'd63}, CAT_TP, 11'd0},
    '{1'b1, '{ACT_NONE,      8'hff, 8'hff, 8'hff, 6'd63, 1'b1, 6'd63}, CAT_TP, 11'd0},
    '{1'b1, '{ACT_COMPARE,   "a",   "A",   "a",   6'd0,  1'b0, 6'd0 }, CAT_TN, 11'd0},
    '{1'b1, '{ACT_COMPARE,   "A",   "C",   "c",   6'd0,  1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b1, '{ACT_COMPARE,   "g",   "G",   "T",   6'd0,  1'b0, 6'd0 }, CAT_FP, 11'd1},
    '{1'b1, '{ACT_COMPARE,   "A",   "C",   "t",   6'd0,  1'b1, 6'd0 }, CAT_FN, 11'd2},
    '{1'b1, '{ACT_NONE,      8'h00, 8'h00, 8'h00, 6'd0,  1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_COMPARE,   8'h00, 8'hff, 8'hff, 6'd63, 1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_COMPARE,   8'hff, 8'hff, 8'h00, 6'd63, 1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_COMPARE,   "z",   "Z",   "{",   6'd63, 1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_COMPARE,   8'h60, 8'h40, 8'h60, 6'd63, 1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_NONE,      8'h00, 8'h00, 8'h00, 6'd5,  1'b0, 6'd9 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_COMPARE,   8'h7a, 8'h5a, 8'h5a, 6'd63, 1'b1, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_READ_CAT,  8'h00, 8'h00, 8'h00, 6'd0,  1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_READ_CAT,  8'h00, 8'h00, 8'h00, 6'd63, 1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_READ_HIST, 8'h00, 8'h00, 8'h00, 6'd0,  1'b0, 6'd2 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_READ_HIST, 8'h00, 8'h00, 8'h00, 6'd63, 1'b0, 6'd3 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_READ_HIST, 8'h00, 8'h00, 8'h00, 6'd0,  1'b0, 6'd0 }, CAT_TP, 11'd0},
    '{1'b0, '{ACT_COMPARE,   8'h41, 8'h41, 8'h41, 6'd42, 1'b1, 6'd63}, CAT_TP, 11'd0},
    '{1'b0, '{ACT_READ_HIST, 8'h00, 8'h00, 8'h00, 6'd42, 1'b0, 6'd0 }, CAT_TP, 11'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ccc_in_if  in_chan ();
  ccc_out_if out_chan ();

  correction_confusion_counter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [47:0]      cat_tally [QUAL_BINS][4];
  logic [47:0]      mis_hist  [QUAL_BINS][HIST_BINS];
  logic [MIS_W-1:0] mis_run;
  rsp_t             pending_rsp [$];
  int               sent_cnt;
  int               mismatch_cnt;
  bit               tx_calm;

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
  endfunction

  function automatic logic [47:0] sat_inc(input logic [47:0] v);
    return (v == CNT_MAX) ? v : v + 48'd1;
  endfunction

  function automatic rsp_t score_base(input base_req_t rq);
    rsp_t        rs;
    logic [7:0]  r, p, c;
    cat_t        cat;
    int          q, bin;
    rs = '0;
    q = (int'(rq.qual) >= QUAL_BINS) ? QUAL_BINS - 1 : int'(rq.qual);
    rs.read_mismatches = mis_run;
    case (rq.action)
      ACT_COMPARE: begin
        r = to_upper(rq.orig_b);
        p = to_upper(rq.true_b);
        c = to_upper(rq.corr_b);
        if (r != p) cat = (c == p) ? CAT_TP : CAT_FN;
        else cat = (c == p) ? CAT_TN : CAT_FP;
        cat_tally[q][cat] = sat_inc(cat_tally[q][cat]);
        if ((cat == CAT_FP || cat == CAT_FN) && int'(mis_run) < MAX_READ_LEN) begin
          mis_run = mis_run + 1'b1;
        end
        rs.category = cat;
        rs.read_mismatches = mis_run;
        if (rq.eor) begin
          bin = (int'(mis_run) > HIST_BINS - 1) ? HIST_BINS - 1 : int'(mis_run);
          mis_hist[q][bin] = sat_inc(mis_hist[q][bin]);
          mis_run = '0;
        end
      end
      ACT_READ_CAT: begin
        rs.tp_total = cat_tally[q][CAT_TP];
        rs.fp_total = cat_tally[q][CAT_FP];
        rs.fn_total = cat_tally[q][CAT_FN];
        rs.tn_total = cat_tally[q][CAT_TN];
      end
      ACT_READ_HIST: begin
        if (int'(rq.hidx) < HIST_BINS) rs.hist_count = mis_hist[q][rq.hidx];
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  task automatic offer_request(input base_req_t rq, input bit pinned = 1'b0,
                               input rsp_t pinned_rsp = '0);
    rsp_t rs;
    int   gap;
    in_chan.valid          <= 1'b1;
    in_chan.action         <= rq.action;
    in_chan.original_base  <= rq.orig_b;
    in_chan.true_base      <= rq.true_b;
    in_chan.corrected_base <= rq.corr_b;
    in_chan.quality_bin    <= rq.qual;
    in_chan.end_of_read    <= rq.eor;
    in_chan.hist_index     <= rq.hidx;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    rs = score_base(rq);
    pending_rsp.push_back(pinned ? pinned_rsp : rs);
    sent_cnt++;
    if (sent_cnt % 128 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 4))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      default: return "N";
    endcase
  endfunction

  function automatic logic [7:0] other_letter(input logic [7:0] p);
    logic [7:0] l;
    do l = pick_letter(); while (l == p);
    return l;
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] b);
    return ($urandom_range(0, 3) == 0) ? (b | 8'h20) : b;
  endfunction

  function automatic logic [5:0] pick_qual();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 6'd0;
    if (r < 5) return 6'd63;
    if (r < 7) return 6'd17;
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic base_req_t random_noise();
    base_req_t rq;
    rq.action = act_t'($urandom_range(0, 3));
    rq.orig_b = 8'($urandom_range(0, 255));
    rq.true_b = 8'($urandom_range(0, 255));
    rq.corr_b = 8'($urandom_range(0, 255));
    rq.qual   = 6'($urandom_range(0, 63));
    rq.eor    = 1'($urandom_range(0, 1));
    rq.hidx   = 6'($urandom_range(0, 63));
    return rq;
  endfunction

  task automatic query_random();
    base_req_t rq;
    int        r;
    rq = random_noise();
    r = $urandom_range(0, 9);
    rq.action = (r < 4) ? ACT_READ_CAT : (r < 9) ? ACT_READ_HIST : ACT_NONE;
    rq.qual = pick_qual();
    r = $urandom_range(0, 9);
    if (r < 6) rq.hidx = 6'($urandom_range(0, 8));
    else if (r < 8) rq.hidx = 6'd63;
    offer_request(rq);
  endtask

  task automatic stream_read(input int len, input logic [5:0] q, input int err_pct);
    base_req_t  rq;
    logic [7:0] r, p, c;
    for (int i = 0; i < len; i++) begin
      p = pick_letter();
      if ($urandom_range(0, 99) >= err_pct) begin
        r = ($urandom_range(0, 3) == 0) ? other_letter(p) : p;
        c = p;
      end else if ($urandom_range(0, 1) == 1) begin
        r = p;
        c = other_letter(p);
      end else begin
        r = other_letter(p);
        c = other_letter(p);
      end
      rq = random_noise();
      rq.action = ACT_COMPARE;
      rq.qual   = q;
      rq.eor    = (i == len - 1);
      if ($urandom_range(0, 49) != 0) begin
        rq.orig_b = vary_case(r);
        rq.true_b = vary_case(p);
        rq.corr_b = vary_case(c);
      end
      offer_request(rq);
      if ($urandom_range(0, 29) == 0) query_random();
    end
  endtask

  task automatic cmp_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result();
    rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("result with no request outstanding");
      mismatch_cnt++;
      return;
    end
    want = pending_rsp.pop_front();
    cmp_field("category", 48'(want.category), 48'(out_chan.category));
    cmp_field("read_mismatches", 48'(want.read_mismatches), 48'(out_chan.read_mismatches));
    cmp_field("tp_total", want.tp_total, out_chan.tp_total);
    cmp_field("fp_total", want.fp_total, out_chan.fp_total);
    cmp_field("fn_total", want.fn_total, out_chan.fn_total);
    cmp_field("tn_total", want.tn_total, out_chan.tn_total);
    cmp_field("hist_count", want.hist_count, out_chan.hist_count);
  endtask

  initial begin : rx_side
    int stall_left;
    int rx_seen;
    bit calm;
    bit squeezed;
    stall_left = 0;
    rx_seen = 0;
    calm = 1'b0;
    squeezed = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        check_result();
        rx_seen++;
        if (rx_seen % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      end
      if (!squeezed && rx_seen >= 400) begin
        squeezed = 1'b1;
        stall_left = 200;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap(1'b0);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : tx_side
    rsp_t pinned_rsp;
    bit   long_done;
    int   sel;
    for (int qi = 0; qi < QUAL_BINS; qi++) begin
      for (int k = 0; k < 4; k++) cat_tally[qi][k] = '0;
      for (int h = 0; h < HIST_BINS; h++) mis_hist[qi][h] = '0;
    end
    mis_run = '0;
    sent_cnt = 0;
    mismatch_cnt = 0;
    tx_calm = 1'b0;
    long_done = 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.action         <= ACT_NONE;
    in_chan.original_base  <= '0;
    in_chan.true_base      <= '0;
    in_chan.corrected_base <= '0;
    in_chan.quality_bin    <= '0;
    in_chan.end_of_read    <= 1'b0;
    in_chan.hist_index     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) begin
      pinned_rsp = '0;
      pinned_rsp.category = DIR_TAB[i].cat;
      pinned_rsp.read_mismatches = DIR_TAB[i].mis;
      offer_request(DIR_TAB[i].rq, DIR_TAB[i].pinned, pinned_rsp);
    end

    while (sent_cnt < ITEMS) begin
      if (!long_done && sent_cnt >= 600) begin
        long_done = 1'b1;
        stream_read(1060, pick_qual(), 100);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70) stream_read($urandom_range(1, 30), pick_qual(), $urandom_range(0, 30));
        else if (sel < 78) stream_read($urandom_range(60, 90), pick_qual(), 95);
        else if (sel < 93) query_random();
        else offer_request(random_noise());
      end
    end
    in_chan.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
